### hdl/assert_macros.svh
// Assertion macros shared by the record decoder RTL.
// No dependencies; each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ERD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold whenever a trigger condition holds.
`define ERD_ASSERT_IMP(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

`endif

### hdl/erd_pkg.sv
// Package for the exercise-log record decoder: record layout constants,
// header byte offsets, divider constants and the structs passed between stages.
// No dependencies.
package erd_pkg;

  localparam int SAMPLE_SLOTS = 20;
  localparam int HEADER_BYTES = 16;
  localparam int SAMPLE_BYTES = 12;

  // Position of the checksum byte within a record.
  localparam int END_POS = HEADER_BYTES + SAMPLE_SLOTS * SAMPLE_BYTES;
  // Byte position saturates one past the checksum byte.
  localparam int POS_W   = $clog2(END_POS + 2);
  localparam int OFF_W   = 4;
  localparam int SB_DEPTH = SAMPLE_BYTES - 1;
  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(SAMPLE_BYTES - 1);

  // Header byte offsets.
  localparam logic [3:0] HDR_COUNT    = 4'd0;
  localparam logic [3:0] HDR_STEP     = 4'd1;
  localparam logic [3:0] HDR_START_B0 = 4'd2;
  localparam logic [3:0] HDR_START_B1 = 4'd3;
  localparam logic [3:0] HDR_START_B2 = 4'd4;
  localparam logic [3:0] HDR_START_B3 = 4'd5;
  localparam logic [3:0] HDR_KF_B0    = 4'd6;
  localparam logic [3:0] HDR_KF_B1    = 4'd7;
  localparam logic [3:0] HDR_WHEEL_B0 = 4'd8;
  localparam logic [3:0] HDR_WHEEL_B1 = 4'd9;

  // Result kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_END    = 1'b1;

  // Divide by 1000 one 16-bit digit at a time: q = (x * DIV_M) >> DIV_SHIFT
  // is exact for x below 2^26.
  localparam int DIV_SHIFT = 36;
  localparam logic [26:0] DIV_M = 27'd68719477;

  typedef struct packed {
    logic        kind;
    logic [15:0] power_watts;
    logic [15:0] cadence_rpm;
    logic [15:0] wheel_turns;
    logic [15:0] altitude_m;
    logic [15:0] speed_tenths;
    logic [7:0]  heart_rate;
    logic [7:0]  temp_thirds;
    logic [32:0] time_seconds;
    logic        checksum_ok;
    logic [15:0] k_factor;
  } erd_res_t;

  // One parsed result on its way to the distance pipeline.
  typedef struct packed {
    logic        valid;
    erd_res_t    res;
    logic [31:0] turn_sum;
    logic [15:0] wheel_mm;
  } erd_work_t;

endpackage

### hdl/erd_parser.sv
// Record parser: byte counter, header fields, slot byte store, checksum and
// saturating turn sum. Registers up to one result per byte. Depends on erd_pkg.
`include "assert_macros.svh"

module erd_parser import erd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  logic [7:0] data_byte,
  input  logic       record_start,
  input  logic       ride_start,
  output erd_work_t  work
);

  localparam logic [4:0] SLOTS5 = 5'(SAMPLE_SLOTS);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [4:0]       idx_r, idx_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [7:0]       step_r, step_nxt;
  logic [31:0]      start_r, start_nxt;
  logic [15:0]      kf_r, kf_nxt;
  logic [15:0]      wheel_r, wheel_nxt;
  logic [7:0]       cks_r, cks_nxt;
  logic [31:0]      tsum_r, tsum_nxt;
  logic [7:0]       sb_r [SB_DEPTH];
  erd_work_t        work_r, work_nxt;

  logic             acc;
  logic             sb_wr;
  logic [POS_W-1:0] pos;
  logic [4:0]       idx;
  logic [OFF_W-1:0] off;
  logic [7:0]       cks;
  logic [31:0]      tsum;
  logic [32:0]      sum_wide;
  logic [31:0]      sum_sat;
  logic [15:0]      turns;
  logic [4:0]       hdr_cnt;

  assign acc = in_valid & en;

  always_comb begin
    // Restart and ride markers take effect before the byte is used.
    pos  = record_start ? '0 : pos_r;
    idx  = record_start ? '0 : idx_r;
    off  = record_start ? '0 : off_r;
    cks  = record_start ? '0 : cks_r;
    tsum = ride_start ? '0 : tsum_r;

    pos_nxt   = pos;
    idx_nxt   = idx;
    off_nxt   = off;
    cks_nxt   = cks;
    tsum_nxt  = tsum;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    start_nxt = start_r;
    kf_nxt    = kf_r;
    wheel_nxt = wheel_r;
    sb_wr     = 1'b0;
    work_nxt  = '0;

    turns    = {sb_r[5], sb_r[4]};
    sum_wide = {1'b0, tsum} + {17'd0, turns};
    sum_sat  = sum_wide[32] ? 32'hffff_ffff : sum_wide[31:0];
    hdr_cnt  = (data_byte[4:0] > SLOTS5) ? SLOTS5 : data_byte[4:0];

    if (pos <= POS_W'(END_POS)) begin
      cks_nxt = cks + data_byte;
      pos_nxt = pos + POS_W'(1);
      if (pos < POS_W'(HEADER_BYTES)) begin
        unique case (pos[3:0])
          HDR_COUNT:    cnt_nxt = hdr_cnt;
          HDR_STEP:     step_nxt = data_byte;
          HDR_START_B0: start_nxt[7:0] = data_byte;
          HDR_START_B1: start_nxt[15:8] = data_byte;
          HDR_START_B2: start_nxt[23:16] = data_byte;
          HDR_START_B3: start_nxt[31:24] = data_byte;
          HDR_KF_B0:    kf_nxt[7:0] = data_byte;
          HDR_KF_B1:    kf_nxt[15:8] = data_byte;
          HDR_WHEEL_B0: wheel_nxt[7:0] = data_byte;
          HDR_WHEEL_B1: wheel_nxt[15:8] = data_byte;
          default: ;
        endcase
      end else if (pos == POS_W'(END_POS)) begin
        work_nxt.valid           = 1'b1;
        work_nxt.res.kind        = KIND_END;
        work_nxt.res.checksum_ok = (cks_nxt == 8'd0);
      end else if (off != LAST_OFF) begin
        sb_wr   = 1'b1;
        off_nxt = off + OFF_W'(1);
      end else begin
        off_nxt = '0;
        idx_nxt = idx + 5'd1;
        if (idx < cnt_r) begin
          tsum_nxt                  = sum_sat;
          work_nxt.valid            = 1'b1;
          work_nxt.res.kind         = KIND_SAMPLE;
          work_nxt.res.power_watts  = {sb_r[1], sb_r[0]};
          work_nxt.res.cadence_rpm  = {sb_r[3], sb_r[2]};
          work_nxt.res.wheel_turns  = turns;
          work_nxt.res.altitude_m   = {sb_r[7], sb_r[6]};
          work_nxt.res.speed_tenths = {sb_r[9], sb_r[8]};
          work_nxt.res.heart_rate   = sb_r[10];
          work_nxt.res.temp_thirds  = data_byte;
          work_nxt.res.time_seconds = {1'b0, start_r} + (33'(idx) * 33'(step_r));
          work_nxt.res.checksum_ok  = 1'b0;
          work_nxt.res.k_factor     = kf_r;
          work_nxt.turn_sum         = sum_sat;
          work_nxt.wheel_mm         = wheel_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      off_r   <= '0;
      idx_r   <= '0;
      cnt_r   <= '0;
      step_r  <= '0;
      start_r <= '0;
      kf_r    <= '0;
      wheel_r <= '0;
      cks_r   <= '0;
      tsum_r  <= '0;
    end else if (acc) begin
      pos_r   <= pos_nxt;
      off_r   <= off_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      start_r <= start_nxt;
      kf_r    <= kf_nxt;
      wheel_r <= wheel_nxt;
      cks_r   <= cks_nxt;
      tsum_r  <= tsum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && sb_wr) begin
      sb_r[off] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r.valid <= 1'b0;
    end else if (en) begin
      work_r.valid <= acc & work_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      work_r.res      <= work_nxt.res;
      work_r.turn_sum <= work_nxt.turn_sum;
      work_r.wheel_mm <= work_nxt.wheel_mm;
    end
  end

  assign work = work_r;

  `ERD_ASSERT(a_pos_range, pos_r <= POS_W'(END_POS + 1), "byte position ran past the record")
  `ERD_ASSERT_IMP(a_off_region, off_r != '0, (pos_r > POS_W'(HEADER_BYTES)) && (pos_r < POS_W'(END_POS)), "slot offset set outside the slot area")

endmodule

### hdl/erd_dist.sv
// Distance pipeline: turn sum times wheel size, then a divide by 1000 done
// as three 16-bit digit steps of two stages each. Depends on erd_pkg.
`include "assert_macros.svh"

module erd_dist import erd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  erd_work_t   work,
  output logic        out_valid,
  output erd_res_t    out_res,
  output logic [38:0] out_dist
);

  // Index 0 holds the product; index k+1 holds the state after digit k.
  logic        vb_r [4];
  erd_res_t    ib_r [4];
  logic [47:0] pb_r [4];
  logic [9:0]  rb_r [4];
  logic [38:0] qb_r [4];

  // Mid-digit stage: dividend digit and its estimated quotient.
  logic        va_r [3];
  erd_res_t    ia_r [3];
  logic [47:0] pa_r [3];
  logic [38:0] qa_r [3];
  logic [25:0] xa_r [3];
  logic [15:0] qd_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r[0] <= 1'b0;
    end else if (en) begin
      vb_r[0] <= work.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ib_r[0] <= work.res;
      pb_r[0] <= 48'(work.turn_sum) * 48'(work.wheel_mm);
      rb_r[0] <= '0;
      qb_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_digit
    logic [25:0] x;
    logic [52:0] prod;
    logic [25:0] q1000;
    logic [25:0] diff;

    // Remainder so far followed by the next 16 bits of the product.
    assign x     = {rb_r[k], pb_r[k][47 - 16*k -: 16]};
    assign prod  = 53'(x) * 53'(DIV_M);
    assign q1000 = (26'(qd_r[k]) << 10) - (26'(qd_r[k]) << 4) - (26'(qd_r[k]) << 3);
    assign diff  = xa_r[k] - q1000;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r[k]   <= 1'b0;
        vb_r[k+1] <= 1'b0;
      end else if (en) begin
        va_r[k]   <= vb_r[k];
        vb_r[k+1] <= va_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ia_r[k]   <= ib_r[k];
        pa_r[k]   <= pb_r[k];
        qa_r[k]   <= qb_r[k];
        xa_r[k]   <= x;
        qd_r[k]   <= prod[DIV_SHIFT+15:DIV_SHIFT];
        ib_r[k+1] <= ia_r[k];
        pb_r[k+1] <= pa_r[k];
        rb_r[k+1] <= diff[9:0];
        qb_r[k+1] <= {qa_r[k][22:0], qd_r[k]};
      end
    end
  end

  assign out_valid = vb_r[3];
  assign out_res   = ib_r[3];
  assign out_dist  = qb_r[3];

  `ERD_ASSERT_IMP(a_rem_d0, vb_r[1], rb_r[1] < 10'd1000, "first digit remainder too large")
  `ERD_ASSERT_IMP(a_rem_d1, vb_r[2], rb_r[2] < 10'd1000, "second digit remainder too large")
  `ERD_ASSERT_IMP(a_rem_d2, vb_r[3], rb_r[3] < 10'd1000, "third digit remainder too large")

endmodule

### hdl/ergometer_record_decoder.sv
// Top level of the exercise-log record decoder: stream ports, parser,
// distance pipeline and output register. Depends on erd_pkg, erd_parser, erd_dist.
//
// The block takes one record byte per beat on the input stream: a 16-byte
// header, SAMPLE_SLOTS slots of 12 bytes, then a checksum byte. Each slot
// below the header's sample count yields one sample beat on the output when
// its last byte arrives, and the checksum byte yields one record end beat.
// An input beat can be taken in every cycle unless the output stalls. A
// result starts from the byte that causes it and is registered in turn in
// the parser register, the 32x16 turn-sum times wheel-size multiplier
// register, the divide-by-1000 pipeline (three 16-bit digits of two
// stages) and the output register. The whole pipeline moves together, so
// while a result waits on out_tready the input is held off as well; with
// out_tready high the block sustains one beat per cycle. Distance uses a
// ride turn sum that persists across records until a beat with ride_start.
`include "assert_macros.svh"

module ergometer_record_decoder import erd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic [1:0]   in_tuser,   // [0] record_start, [1] ride_start
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] power_watts, [31:16] cadence_rpm, [47:32] wheel_turns,
  // [63:48] altitude_m, [79:64] speed_tenths, [87:80] heart_rate,
  // [95:88] temp_thirds, [134:96] distance_m, [167:135] time_seconds,
  // [168] checksum_ok, [184:169] k_factor, [191:185] zero
  output logic [191:0] out_tdata,
  output logic [0:0]   out_tuser   // [0] kind
);

  // The pipeline advances whenever the output register is empty or drained.
  logic        en;
  erd_work_t   work;
  logic        dist_valid;
  erd_res_t    dist_res;
  logic [38:0] dist_m;

  logic        out_valid_r;
  erd_res_t    out_res_r;
  logic [38:0] out_dist_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  erd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_tvalid),
    .data_byte    (in_tdata),
    .record_start (in_tuser[0]),
    .ride_start   (in_tuser[1]),
    .work         (work)
  );

  erd_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .work      (work),
    .out_valid (dist_valid),
    .out_res   (dist_res),
    .out_dist  (dist_m)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dist_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r  <= dist_res;
      out_dist_r <= dist_m;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.kind;
  assign out_tdata  = {7'd0,
                       out_res_r.k_factor,
                       out_res_r.checksum_ok,
                       out_res_r.time_seconds,
                       out_dist_r,
                       out_res_r.temp_thirds,
                       out_res_r.heart_rate,
                       out_res_r.speed_tenths,
                       out_res_r.altitude_m,
                       out_res_r.wheel_turns,
                       out_res_r.cadence_rpm,
                       out_res_r.power_watts};

  // A record end carries a zero turn sum and wheel size, so its distance is zero.
  `ERD_ASSERT_IMP(a_end_no_dist, out_valid_r && (out_res_r.kind == KIND_END), out_dist_r == '0, "record end beat with nonzero distance")

endmodule
